### design/rss_pkg.sv
// Shared types, constants and helpers for the RGB 3x3 sharpening stream.
package rss_pkg;

   // Line and frame limits.
   localparam int MAX_LINE = 1024;
   localparam int MAX_ROWS = 4096;
   localparam int COL_W    = $clog2(MAX_LINE);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Register fields.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   // Result queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   // Nine taps of one channel, row major, centre at index 4.
   typedef logic [8:0][7:0] taps_type;

   typedef struct packed {
      logic             wr_en;
      logic [COL_W-1:0] addr;
      pix_type          pix;
   } lb_req_type;

   typedef struct packed {
      pix_type up;
      pix_type mid;
   } lb_rsp_type;

   typedef struct packed {
      logic             emit;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             frame_done;
   } tag_type;

   typedef struct packed {
      pix_type          pix;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             frame_done;
   } rsp_type;

   function automatic logic [WIDTH_REG_W-1:0] eff_width(input logic [WIDTH_REG_W-1:0] w);
      logic [WIDTH_REG_W-1:0] res;
      res = w;
      if (w < WIDTH_REG_W'(3)) res = WIDTH_REG_W'(3);
      else if (w > WIDTH_REG_W'(MAX_LINE)) res = WIDTH_REG_W'(MAX_LINE);
      return res;
   endfunction

   function automatic logic [HEIGHT_REG_W-1:0] eff_height(input logic [HEIGHT_REG_W-1:0] h);
      logic [HEIGHT_REG_W-1:0] res;
      res = h;
      if (h < HEIGHT_REG_W'(3)) res = HEIGHT_REG_W'(3);
      else if (h > HEIGHT_REG_W'(MAX_ROWS)) res = HEIGHT_REG_W'(MAX_ROWS);
      return res;
   endfunction

endpackage

### design/rss_line_buf.sv
// Two line stores with registered reads and a delayed write-back of the upper line.
module rss_line_buf (
   input  logic                clock,
   input  logic                reset,
   input  rss_pkg::lb_req_type lb_req,
   output rss_pkg::lb_rsp_type lb_rsp
);

   rss_pkg::pix_type upper_mem [rss_pkg::MAX_LINE];
   rss_pkg::pix_type middle_mem [rss_pkg::MAX_LINE];

   rss_pkg::pix_type              up_rd_ff;
   rss_pkg::pix_type              mid_rd_ff;
   logic                          wb_vld_ff;
   logic [rss_pkg::COL_W-1:0]     wb_addr_ff;

   // Middle store: read old, write the new pixel at the same column.
   always_ff @(posedge clock) begin
      if (lb_req.wr_en) begin
         mid_rd_ff               <= middle_mem[lb_req.addr];
         middle_mem[lb_req.addr] <= lb_req.pix;
      end
   end

   // Upper store: read now, write back the old middle entry in the next cycle.
   always_ff @(posedge clock) begin
      if (lb_req.wr_en) begin
         up_rd_ff <= upper_mem[lb_req.addr];
      end
      if (wb_vld_ff) begin
         upper_mem[wb_addr_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_vld_ff <= 1'b0;
      end else begin
         wb_vld_ff <= lb_req.wr_en;
      end
      wb_addr_ff <= lb_req.addr;
   end

   assign lb_rsp.up  = up_rd_ff;
   assign lb_rsp.mid = mid_rd_ff;

endmodule

### design/rss_lane.sv
// One channel of the sharpening kernel: 9x centre minus neighbours, clamped, registered.
module rss_lane (
   input  logic              clock,
   input  rss_pkg::taps_type taps,
   output logic [7:0]        result
);

   logic [11:0]        centre9;
   logic [10:0]        ring_sum;
   logic signed [12:0] diff;
   logic [7:0]         result_in;
   logic [7:0]         result_ff;

   always_comb begin
      centre9  = {1'b0, taps[4], 3'b000} + 12'(taps[4]);
      ring_sum = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) ring_sum = ring_sum + 11'(taps[k]);
      end
      diff = $signed({1'b0, centre9}) - $signed({2'b00, ring_sum});
      if (diff < 13'sd0) result_in = 8'd0;
      else if (diff > 13'sd255) result_in = 8'd255;
      else result_in = diff[7:0];
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### design/rgb_sharpen_3x3_stream.sv
// Top level of the RGB 3x3 sharpening stream: counters, window, lanes, merge and result queue.
//
// Usage:
//   Pixels enter in raster order on the req_ channel, one transfer per pixel,
//   transferred when req_valid is high and req_stall is low. Each interior pixel
//   yields one result on the rsp_ channel (sharpened RGB plus centre column and
//   row); border pixels yield none. rsp_frame_done marks the last result of a frame.
//   The csr_ port sets image_width (index 0) and image_height (index 1); either
//   write restarts the frame at column 0, row 0. Write only while the block is idle.
// Path: a pixel's result passes stage 1, the stage 2 window and the stage 3 lane
//   registers, then is written to the result queue and transferred from there.
// Throughput: one pixel per cycle while req_stall is low; the line stores are read once and
//   written once per pixel, and the three colour lanes work in parallel.
// Stall: the eight-entry result queue absorbs a stalled receiver; req_stall rises
//   when queued plus in-flight results would fill it, so nothing is dropped.
// Reset: counters to zero, size 640 x 480, window to zero, queue empty. The line
//   stores are not cleared; the first two lines of each frame overwrite them.
module rgb_sharpen_3x3_stream (
   input  logic                               clock,
   input  logic                               reset,
   // pixel input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_in_red,
   input  logic [7:0]                         req_in_green,
   input  logic [7:0]                         req_in_blue,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_red,
   output logic [7:0]                         rsp_out_green,
   output logic [7:0]                         rsp_out_blue,
   output logic [rss_pkg::COL_W-1:0]          rsp_out_col,
   output logic [rss_pkg::ROW_W-1:0]          rsp_out_row,
   output logic                               rsp_frame_done,
   // register writes
   input  logic                               csr_we,
   input  logic [rss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W = rss_pkg::COL_W;
   localparam int ROW_W = rss_pkg::ROW_W;
   localparam int WW    = rss_pkg::WIDTH_REG_W;
   localparam int HW    = rss_pkg::HEIGHT_REG_W;
   localparam int CW    = rss_pkg::FIFO_CNT_W;
   localparam int PW    = rss_pkg::FIFO_PTR_W;

   // ---------------------------------------------------------------------
   // Size registers and raster counters
   // ---------------------------------------------------------------------
   logic [WW-1:0]    width_ff;
   logic [HW-1:0]    height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WW-1:0]    w_eff;
   logic [HW-1:0]    h_eff;
   logic             last_col, last_row;
   logic             req_accept;
   rss_pkg::tag_type tag_in;
   rss_pkg::pix_type req_pix;

   assign req_accept = req_valid && !req_stall;
   assign req_pix    = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   always_comb begin
      w_eff    = rss_pkg::eff_width(width_ff);
      h_eff    = rss_pkg::eff_height(height_ff);
      last_col = (WW'(col_ff) + WW'(1)) >= w_eff;
      last_row = (HW'(row_ff) + HW'(1)) >= h_eff;
      col_in   = col_ff + COL_W'(1);
      row_in   = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end
      // interior centre sits one row up and one column left
      tag_in.emit       = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      tag_in.col        = col_ff - COL_W'(1);
      tag_in.row        = row_ff - ROW_W'(1);
      tag_in.frame_done = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rss_pkg::WIDTH_RESET;
         height_ff <= rss_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         // restart the frame on a known register; ignore other indexes
         case (csr_index)
            rss_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[WW-1:0];
               col_ff   <= '0;
               row_ff   <= '0;
            end
            rss_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[HW-1:0];
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
            end
         endcase
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line stores (read at transfer, data back in the next cycle)
   // ---------------------------------------------------------------------
   rss_pkg::lb_req_type lb_req;
   rss_pkg::lb_rsp_type lb_rsp;

   assign lb_req = '{wr_en: req_accept, addr: col_ff, pix: req_pix};

   rss_line_buf u_line_buf (
      .clock  (clock),
      .reset  (reset),
      .lb_req (lb_req),
      .lb_rsp (lb_rsp)
   );

   // ---------------------------------------------------------------------
   // Stage 1: hold the pixel and its tag while the stores are read
   // ---------------------------------------------------------------------
   logic             s1_vld_ff;
   rss_pkg::tag_type s1_tag_ff;
   rss_pkg::pix_type s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_tag_ff <= '0;
      end else begin
         s1_vld_ff <= req_accept;
         s1_tag_ff <= tag_in;
      end
      s1_pix_ff <= req_pix;
   end

   // ---------------------------------------------------------------------
   // Stage 2: advance the 3x3 window by one column per pixel
   // ---------------------------------------------------------------------
   rss_pkg::pix_type win_ff [3][3];
   rss_pkg::tag_type s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
         s2_tag_ff <= '0;
      end else begin
         if (s1_vld_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= lb_rsp.up;
            win_ff[1][2] <= lb_rsp.mid;
            win_ff[2][2] <= s1_pix_ff;
         end
         s2_tag_ff <= '{emit:       s1_vld_ff && s1_tag_ff.emit,
                        col:        s1_tag_ff.col,
                        row:        s1_tag_ff.row,
                        frame_done: s1_tag_ff.frame_done};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: three colour lanes in parallel
   // ---------------------------------------------------------------------
   rss_pkg::taps_type red_taps, green_taps, blue_taps;
   logic [7:0]        red_res, green_res, blue_res;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            red_taps[i*3+j]   = win_ff[i][j].red;
            green_taps[i*3+j] = win_ff[i][j].green;
            blue_taps[i*3+j]  = win_ff[i][j].blue;
         end
      end
   end

   rss_lane u_lane_red   (.clock(clock), .taps(red_taps),   .result(red_res));
   rss_lane u_lane_green (.clock(clock), .taps(green_taps), .result(green_res));
   rss_lane u_lane_blue  (.clock(clock), .taps(blue_taps),  .result(blue_res));

   logic             s3_vld_ff;
   rss_pkg::tag_type s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_tag_ff.emit;
      end
      s3_tag_ff <= s2_tag_ff;
   end

   // ---------------------------------------------------------------------
   // Merge: pack the lane results with the coordinates into the queue
   // ---------------------------------------------------------------------
   rss_pkg::rsp_type fifo_wdata;
   rss_pkg::rsp_type fifo_mem_ff [rss_pkg::FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    fifo_cnt_ff;
   logic [CW-1:0]    credit_used;
   logic             rsp_accept;
   rss_pkg::rsp_type rsp_head;

   assign fifo_wdata = '{pix:        '{red: red_res, green: green_res, blue: blue_res},
                         col:        s3_tag_ff.col,
                         row:        s3_tag_ff.row,
                         frame_done: s3_tag_ff.frame_done};

   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= fifo_wdata;
      end
   end

   assign rsp_valid  = fifo_cnt_ff != '0;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s3_vld_ff) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (rsp_accept) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         fifo_cnt_ff <= fifo_cnt_ff + CW'(s3_vld_ff) - CW'(rsp_accept);
      end
   end

   // Stall input when queued plus in-flight results could fill the queue.
   assign credit_used = fifo_cnt_ff + CW'(s1_vld_ff && s1_tag_ff.emit)
                      + CW'(s2_tag_ff.emit) + CW'(s3_vld_ff);
   assign req_stall   = credit_used >= CW'(rss_pkg::FIFO_DEPTH);

   assign rsp_head       = fifo_mem_ff[rd_ptr_ff];
   assign rsp_out_red    = rsp_head.pix.red;
   assign rsp_out_green  = rsp_head.pix.green;
   assign rsp_out_blue   = rsp_head.pix.blue;
   assign rsp_out_col    = rsp_head.col;
   assign rsp_out_row    = rsp_head.row;
   assign rsp_frame_done = rsp_head.frame_done;

`ifndef SYNTHESIS
   // credit scheme must never overrun the result queue
   assert property (@(posedge clock) disable iff (reset)
      credit_used <= CW'(rss_pkg::FIFO_DEPTH))
      else $error("result queue credit overrun");

   // a result reaches the merge stage only from a pixel transfer that passed stages 1 to 3
   assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> $past(req_accept, 3))
      else $error("result without matching pixel transfer");

   // a write into the queue is never lost to a full queue
   assert property (@(posedge clock) disable iff (reset)
      (s3_vld_ff && !rsp_accept) |=> fifo_cnt_ff == $past(fifo_cnt_ff) + CW'(1))
      else $error("queue count did not track a write");
`endif

endmodule
